[src/pmc_pkg.sv]
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared types, constants and helpers for the partition mismatch counter.
// ----------------------------------------------------------------------------
package pmc_pkg;

    // Geometry of one comparison
    localparam int MAX_PARTS  = 4;
    localparam int MAP_BITS   = 64;
    localparam int MAP_BYTES  = MAP_BITS / 8;
    localparam int NUM_PERMS  = 24;
    localparam int GROUPS     = 4;
    localparam int GROUP_SIZE = NUM_PERMS / GROUPS;

    typedef logic [MAP_BITS-1:0] map_t;
    typedef logic [3:0]          nib_t;    // ones in one byte, 0..8
    typedef logic [6:0]          cost_t;   // ones in one word, 0..64
    typedef logic [8:0]          sum_t;    // sum over four pairs, 0..256
    typedef logic [2:0]          parts_t;  // partition count field
    typedef logic [1:0]          col_t;    // partition label

    // Candidate that must never win the minimum
    localparam sum_t SUM_NONE = '1;

    // Per-stage control carried alongside the payload
    typedef struct packed {
        logic   valid;
        parts_t parts;
    } ctl_t;

    // All label assignments of four partitions, row r goes to column PERM[k][r].
    // Entries that fix the upper rows cover the smaller partition counts.
    localparam col_t PERM [NUM_PERMS][MAX_PARTS] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd3, 2'd2},
        '{2'd0, 2'd2, 2'd1, 2'd3}, '{2'd0, 2'd2, 2'd3, 2'd1},
        '{2'd0, 2'd3, 2'd1, 2'd2}, '{2'd0, 2'd3, 2'd2, 2'd1},
        '{2'd1, 2'd0, 2'd2, 2'd3}, '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd1, 2'd2, 2'd0, 2'd3}, '{2'd1, 2'd2, 2'd3, 2'd0},
        '{2'd1, 2'd3, 2'd0, 2'd2}, '{2'd1, 2'd3, 2'd2, 2'd0},
        '{2'd2, 2'd0, 2'd1, 2'd3}, '{2'd2, 2'd0, 2'd3, 2'd1},
        '{2'd2, 2'd1, 2'd0, 2'd3}, '{2'd2, 2'd1, 2'd3, 2'd0},
        '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd2, 2'd3, 2'd1, 2'd0},
        '{2'd3, 2'd0, 2'd1, 2'd2}, '{2'd3, 2'd0, 2'd2, 2'd1},
        '{2'd3, 2'd1, 2'd0, 2'd2}, '{2'd3, 2'd1, 2'd2, 2'd0},
        '{2'd3, 2'd2, 2'd0, 2'd1}, '{2'd3, 2'd2, 2'd1, 2'd0}
    };

    // Counts other than two or three run as four
    function automatic parts_t decode_parts(input parts_t raw);
        parts_t n;
        n = raw;
        if (raw != 3'd2 && raw != 3'd3)
        begin
            n = 3'd4;
        end
        return n;
    endfunction

endpackage

[src/partition_mismatch_count_core.sv]
// ----------------------------------------------------------------------------
// partition_mismatch_count_core
// Minimum label-assignment mismatch between a block's partition bitmaps and
// one partitioning table entry, five-stage pipeline.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   input    | in_valid / in_ready | part_count, block_map_0..3, table_map_0..3
//   output   | out_valid/out_ready | mismatch
//
// One transaction per cycle while the output is not stalled.
// Stages: byte popcounts, word popcounts, assignment sums, group minima,
// final minimum into the output register.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage. Reset clears the stage control registers only.
// ----------------------------------------------------------------------------
module partition_mismatch_count_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  part_count,
    input  logic [63:0] block_map_0,
    input  logic [63:0] block_map_1,
    input  logic [63:0] block_map_2,
    input  logic [63:0] block_map_3,
    input  logic [63:0] table_map_0,
    input  logic [63:0] table_map_1,
    input  logic [63:0] table_map_2,
    input  logic [63:0] table_map_3,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  mismatch
);
    import pmc_pkg::*;

    logic   advance;
    map_t   block_map [MAX_PARTS];
    map_t   table_map [MAX_PARTS];
    cost_t  cost      [MAX_PARTS][MAX_PARTS];
    sum_t   sum       [NUM_PERMS];
    logic [NUM_PERMS-1:0] ok;

    ctl_t   s1_ctl_reg;
    ctl_t   s1_ctl_next;
    ctl_t   s2_ctl_reg;
    logic   s3_valid_reg;
    logic   s4_valid_reg;
    logic   out_valid_reg;

    // Pipeline moves when the output slot frees up
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    assign block_map = '{block_map_0, block_map_1, block_map_2, block_map_3};
    assign table_map = '{table_map_0, table_map_1, table_map_2, table_map_3};

    // Control entering stage 1
    always_comb
    begin
        s1_ctl_next.valid = in_valid;
        s1_ctl_next.parts = decode_parts(part_count);
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg    <= '0;
            s2_ctl_reg    <= '0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_ctl_reg    <= s1_ctl_next;
            s2_ctl_reg    <= s1_ctl_reg;
            s3_valid_reg  <= s2_ctl_reg.valid;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    // Stages 1-2
    pmc_popcnt u_popcnt
    (
        .clk       (clk),
        .en        (advance),
        .block_map (block_map),
        .table_map (table_map),
        .cost      (cost)
    );

    // Stage 3
    pmc_assign u_assign
    (
        .clk  (clk),
        .en   (advance),
        .ctl  (s2_ctl_reg),
        .cost (cost),
        .sum  (sum),
        .ok   (ok)
    );

    // Stages 4-5
    pmc_min u_min
    (
        .clk      (clk),
        .en       (advance),
        .sum      (sum),
        .ok       (ok),
        .mismatch (mismatch)
    );

    assign out_valid = out_valid_reg;

    // Checks
    a_in_enters_stage1 : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_ctl_reg.valid)
        else $error("accepted transaction did not enter stage 1");

    a_some_assignment : assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> ok != '0)
        else $error("no applicable label assignment");

    a_result_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mismatch <= 8'd128)
        else $error("mismatch out of range");

    a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

endmodule

[src/pmc_popcnt.sv]
// ----------------------------------------------------------------------------
// pmc_popcnt
// XOR of every block bitmap with every table bitmap and its population
// count, in two register stages: byte counts, then word counts.
// ----------------------------------------------------------------------------
module pmc_popcnt
(
    input  logic         clk,
    input  logic         en,
    input  pmc_pkg::map_t block_map [pmc_pkg::MAX_PARTS],
    input  pmc_pkg::map_t table_map [pmc_pkg::MAX_PARTS],
    output pmc_pkg::cost_t cost [pmc_pkg::MAX_PARTS][pmc_pkg::MAX_PARTS]
);
    import pmc_pkg::*;

    nib_t  byte_cnt_reg  [MAX_PARTS][MAX_PARTS][MAP_BYTES];
    nib_t  byte_cnt_next [MAX_PARTS][MAX_PARTS][MAP_BYTES];
    cost_t cost_reg      [MAX_PARTS][MAX_PARTS];
    cost_t cost_next     [MAX_PARTS][MAX_PARTS];

    function automatic nib_t byte_ones(input logic [7:0] b);
        nib_t c;
        c = '0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + nib_t'(b[i]);
        end
        return c;
    endfunction

    // Stage 1: ones per byte of each XOR word
    always_comb
    begin
        for (int i = 0; i < MAX_PARTS; i++)
        begin
            for (int j = 0; j < MAX_PARTS; j++)
            begin
                for (int b = 0; b < MAP_BYTES; b++)
                begin
                    byte_cnt_next[i][j][b] =
                        byte_ones(block_map[i][b*8 +: 8] ^ table_map[j][b*8 +: 8]);
                end
            end
        end
    end

    // Stage 2: ones per word
    always_comb
    begin
        for (int i = 0; i < MAX_PARTS; i++)
        begin
            for (int j = 0; j < MAX_PARTS; j++)
            begin
                cost_next[i][j] = '0;
                for (int b = 0; b < MAP_BYTES; b++)
                begin
                    cost_next[i][j] = cost_next[i][j] + cost_t'(byte_cnt_reg[i][j][b]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            byte_cnt_reg <= byte_cnt_next;
            cost_reg     <= cost_next;
        end
    end

    assign cost = cost_reg;

endmodule

[src/pmc_assign.sv]
// ----------------------------------------------------------------------------
// pmc_assign
// Summed cost of every label assignment, one register stage. Rows at or
// above the partition count add nothing; assignments that move those rows
// are flagged as not applicable.
// ----------------------------------------------------------------------------
module pmc_assign
(
    input  logic           clk,
    input  logic           en,
    input  pmc_pkg::ctl_t  ctl,
    input  pmc_pkg::cost_t cost [pmc_pkg::MAX_PARTS][pmc_pkg::MAX_PARTS],
    output pmc_pkg::sum_t  sum  [pmc_pkg::NUM_PERMS],
    output logic [pmc_pkg::NUM_PERMS-1:0] ok
);
    import pmc_pkg::*;

    sum_t                 sum_reg  [NUM_PERMS];
    sum_t                 sum_next [NUM_PERMS];
    logic [NUM_PERMS-1:0] ok_reg;
    logic [NUM_PERMS-1:0] ok_next;

    // Stage 3: one four-operand add per assignment
    always_comb
    begin
        for (int k = 0; k < NUM_PERMS; k++)
        begin
            sum_next[k] = '0;
            ok_next[k]  = 1'b1;
            for (int r = 0; r < MAX_PARTS; r++)
            begin
                if (r < int'(ctl.parts))
                begin
                    sum_next[k] = sum_next[k] + sum_t'(cost[r][PERM[k][r]]);
                end
                else if (int'(PERM[k][r]) != r)
                begin
                    ok_next[k] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
            ok_reg  <= ok_next;
        end
    end

    assign sum = sum_reg;
    assign ok  = ok_reg;

endmodule

[src/pmc_min.sv]
// ----------------------------------------------------------------------------
// pmc_min
// Minimum over the applicable assignment sums, in two register stages
// (group minima, then the final minimum), halved on the way out.
// ----------------------------------------------------------------------------
module pmc_min
(
    input  logic          clk,
    input  logic          en,
    input  pmc_pkg::sum_t sum [pmc_pkg::NUM_PERMS],
    input  logic [pmc_pkg::NUM_PERMS-1:0] ok,
    output logic [7:0]    mismatch
);
    import pmc_pkg::*;

    sum_t       grp_min_reg  [GROUPS];
    sum_t       grp_min_next [GROUPS];
    logic [7:0] mismatch_reg;
    logic [7:0] mismatch_next;

    // Stage 4: minimum within each group
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_min_next[g] = SUM_NONE;
            for (int e = 0; e < GROUP_SIZE; e++)
            begin
                if (ok[g*GROUP_SIZE + e] && sum[g*GROUP_SIZE + e] < grp_min_next[g])
                begin
                    grp_min_next[g] = sum[g*GROUP_SIZE + e];
                end
            end
        end
    end

    // Stage 5: minimum of the groups, halved with floor
    always_comb
    begin
        sum_t best;
        best = grp_min_reg[0];
        for (int g = 1; g < GROUPS; g++)
        begin
            if (grp_min_reg[g] < best)
            begin
                best = grp_min_reg[g];
            end
        end
        mismatch_next = best[8:1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grp_min_reg  <= grp_min_next;
            mismatch_reg <= mismatch_next;
        end
    end

    assign mismatch = mismatch_reg;

endmodule

[tb/partition_mismatch_count_checker.sv]
// ----------------------------------------------------------------------------
// partition_mismatch_count_checker
// Watches both channels of the partition mismatch counter. Each accepted
// input transaction is turned into the expected minimum mismatch, and each
// accepted output transaction is compared in order with the oldest one.
// ----------------------------------------------------------------------------
module partition_mismatch_count_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  part_count,
    input  logic [63:0] block_map_0,
    input  logic [63:0] block_map_1,
    input  logic [63:0] block_map_2,
    input  logic [63:0] block_map_3,
    input  logic [63:0] table_map_0,
    input  logic [63:0] table_map_1,
    input  logic [63:0] table_map_2,
    input  logic [63:0] table_map_3,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  mismatch,
    output int          fail_count,
    output int          pending
);
    import pmc_pkg::*;

    // Expected counts, oldest first
    logic [7:0] expected_mismatch_q [$];
    int         result_idx;

    // Minimum over all one-to-one label assignments of the summed XOR
    // popcounts, halved with a floor
    function automatic logic [7:0] predict_min_mismatch(
        input parts_t pc,
        input map_t   b0, input map_t b1, input map_t b2, input map_t b3,
        input map_t   t0, input map_t t1, input map_t t2, input map_t t3);
        map_t bm [4];
        map_t tm [4];
        int   cost [4][4];
        int   n;
        int   best;
        int   sum;
        int   col;
        bit   ok;
        bit   [3:0] used;
        bm[0] = b0; bm[1] = b1; bm[2] = b2; bm[3] = b3;
        tm[0] = t0; tm[1] = t1; tm[2] = t2; tm[3] = t3;
        // counts other than two or three run as four partitions
        n = (pc == 3'd2 || pc == 3'd3) ? int'(pc) : 4;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                cost[i][j] = $countones(bm[i] ^ tm[j]);
            end
        end
        best = 1000;
        // two bits of code per row pick its column; rows past n must pick 0
        for (int code = 0; code < 256; code++)
        begin
            ok   = 1'b1;
            used = '0;
            sum  = 0;
            for (int r = 0; r < 4; r++)
            begin
                col = (code >> (2 * r)) & 3;
                if (r < n)
                begin
                    if (col >= n || used[col])
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        used[col] = 1'b1;
                        sum += cost[r][col];
                    end
                end
                else if (col != 0)
                begin
                    ok = 1'b0;
                end
            end
            if (ok && sum < best)
            begin
                best = sum;
            end
        end
        return 8'(best / 2);
    endfunction

    assign pending = expected_mismatch_q.size();

    // Sample pre-edge values of both channels; results are matched before
    // the new input is queued
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_mismatch_q.delete();
            fail_count <= 0;
            result_idx <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_idx <= result_idx + 1;
                if (expected_mismatch_q.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("result %0d: unexpected transaction, mismatch=%0d",
                                 result_idx, mismatch);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (mismatch !== expected_mismatch_q[0])
                    begin
                        if (fail_count < 10)
                        begin
                            $display("result %0d: mismatch expected %0d, got %0d",
                                     result_idx, expected_mismatch_q[0], mismatch);
                        end
                        fail_count <= fail_count + 1;
                    end
                    void'(expected_mismatch_q.pop_front());
                end
            end
            if (in_valid && in_ready)
            begin
                expected_mismatch_q.insert(expected_mismatch_q.size(),
                    predict_min_mismatch(part_count,
                    block_map_0, block_map_1, block_map_2, block_map_3,
                    table_map_0, table_map_1, table_map_2, table_map_3));
            end
        end
    end

endmodule

[tb/partition_mismatch_count_core_tb.sv]
// ----------------------------------------------------------------------------
// partition_mismatch_count_core_tb
// Drives the partition mismatch counter with directed corner cases, then
// random partitionings (relabeled and perturbed copies of the block labels)
// mixed with raw noise, under random source gaps and sink stalls. The
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module partition_mismatch_count_core_tb;
    import pmc_pkg::*;

    localparam int   RANDOM_ITEMS = 1130;
    localparam int   IDLE_LIMIT   = 2000;
    localparam int   DRAIN_CYCLES = 12;
    localparam map_t ONES         = '1;
    localparam map_t ZEROS        = '0;
    localparam map_t ALT_A        = 64'h5555_5555_5555_5555;
    localparam map_t ALT_B        = 64'hAAAA_AAAA_AAAA_AAAA;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  part_count;
    logic [63:0] block_map_0;
    logic [63:0] block_map_1;
    logic [63:0] block_map_2;
    logic [63:0] block_map_3;
    logic [63:0] table_map_0;
    logic [63:0] table_map_1;
    logic [63:0] table_map_2;
    logic [63:0] table_map_3;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  mismatch;

    int fail_count;
    int pending;
    int idle_cycles;
    int src_burst_left;
    int sink_burst_left;

    partition_mismatch_count_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .part_count  (part_count),
        .block_map_0 (block_map_0),
        .block_map_1 (block_map_1),
        .block_map_2 (block_map_2),
        .block_map_3 (block_map_3),
        .table_map_0 (table_map_0),
        .table_map_1 (table_map_1),
        .table_map_2 (table_map_2),
        .table_map_3 (table_map_3),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mismatch    (mismatch)
    );

    partition_mismatch_count_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .part_count  (part_count),
        .block_map_0 (block_map_0),
        .block_map_1 (block_map_1),
        .block_map_2 (block_map_2),
        .block_map_3 (block_map_3),
        .table_map_0 (table_map_0),
        .table_map_1 (table_map_1),
        .table_map_2 (table_map_2),
        .table_map_3 (table_map_3),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mismatch    (mismatch),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Draw an idle count, with occasional stretches of back-to-back traffic
    function automatic int draw_gap(ref int burst_left);
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            burst_left = $urandom_range(20, 60);
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 10);
        end
        return gap;
    endfunction

    // Present one input transaction and hold it until accepted
    task automatic send_item(input parts_t pc,
                             input map_t b0, input map_t b1,
                             input map_t b2, input map_t b3,
                             input map_t t0, input map_t t1,
                             input map_t t2, input map_t t3);
        int gap;
        gap = draw_gap(src_burst_left);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        part_count  <= pc;
        block_map_0 <= b0;
        block_map_1 <= b1;
        block_map_2 <= b2;
        block_map_3 <= b3;
        table_map_0 <= t0;
        table_map_1 <= t1;
        table_map_2 <= t2;
        table_map_3 <= t3;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic map_t rand_map();
        return {$urandom, $urandom};
    endfunction

    // Partition count: mostly 2, 3 or 4, sometimes an out-of-range code
    function automatic parts_t rand_parts();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 3'd2;
        else if (r < 6)
            return 3'd3;
        else if (r < 9)
            return 3'd4;
        r = $urandom_range(0, 4);
        return parts_t'((r < 2) ? r : r + 3);
    endfunction

    // Well-formed block labeling; the table is a relabeled copy with some
    // texels moved, and the unused words carry garbage
    task automatic send_partitioned();
        parts_t pc;
        int     n;
        int     perm [4];
        int     tmp;
        int     k;
        int     lab;
        int     tlab;
        int     move_rate;
        map_t   b [4];
        map_t   t [4];
        pc = rand_parts();
        n  = (pc == 3'd2 || pc == 3'd3) ? int'(pc) : 4;
        for (int i = 0; i < 4; i++)
        begin
            perm[i] = i;
            b[i] = (i < n) ? ZEROS : rand_map();
            t[i] = (i < n) ? ZEROS : rand_map();
        end
        for (int i = n - 1; i > 0; i--)
        begin
            k       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[k];
            perm[k] = tmp;
        end
        move_rate = $urandom_range(0, 4);
        for (int tx = 0; tx < MAP_BITS; tx++)
        begin
            lab = $urandom_range(0, n - 1);
            b[lab][tx] = 1'b1;
            if ($urandom_range(0, 15) < move_rate)
                tlab = $urandom_range(0, n - 1);
            else
                tlab = perm[lab];
            t[tlab][tx] = 1'b1;
        end
        send_item(pc, b[0], b[1], b[2], b[3], t[0], t[1], t[2], t[3]);
    endtask

    // Raw noise with mixed bit densities
    task automatic send_noise();
        map_t m [8];
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(0, 3))
                0: m[i] = rand_map() & rand_map();
                1: m[i] = rand_map() | rand_map();
                default: m[i] = rand_map();
            endcase
        end
        send_item(parts_t'($urandom_range(0, 7)),
                  m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7]);
    endtask

    // Output side: random stall before each transaction
    initial
    begin
        int stall;
        out_ready       <= 1'b0;
        sink_burst_left = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = draw_gap(sink_burst_left);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        map_t r0;
        map_t r1;
        map_t r2;
        map_t r3;
        rst_n          = 1'b0;
        in_valid       <= 1'b0;
        part_count     <= '0;
        block_map_0    <= '0;
        block_map_1    <= '0;
        block_map_2    <= '0;
        block_map_3    <= '0;
        table_map_0    <= '0;
        table_map_1    <= '0;
        table_map_2    <= '0;
        table_map_3    <= '0;
        idle_cycles    = 0;
        src_burst_left = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all empty, all full, worst case per partition count
        send_item(3'd2, ZEROS, ZEROS, ZEROS, ZEROS, ZEROS, ZEROS, ZEROS, ZEROS);
        send_item(3'd4, ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES);
        send_item(3'd4, ONES, ONES, ONES, ONES, ZEROS, ZEROS, ZEROS, ZEROS);
        send_item(3'd3, ONES, ONES, ONES, ZEROS, ZEROS, ZEROS, ZEROS, ONES);
        send_item(3'd2, ONES, ONES, ZEROS, ZEROS, ZEROS, ZEROS, ONES, ONES);
        send_item(3'd4, ZEROS, ZEROS, ZEROS, ZEROS, ONES, ONES, ONES, ONES);
        // identical or relabeled partitions match perfectly, garbage in unused words
        send_item(3'd2, ALT_A, ALT_B, ONES, ALT_A, ALT_B, ALT_A, ZEROS, ONES);
        send_item(3'd2, ALT_A, ALT_B, ZEROS, ZEROS, ALT_A, ALT_B, ONES, ALT_A);
        r0 = 64'h0000_0000_FFFF_FFFF;
        r1 = 64'h0000_FFFF_0000_0000;
        r2 = 64'hFFFF_0000_0000_0000;
        send_item(3'd3, r0, r1, r2, ONES, r2, r0, r1, ALT_B);
        send_item(3'd3, r0, r1, r2, ZEROS, r0, r2, r1, ONES);
        r3 = 64'h0F0F_0F0F_0F0F_0F0F;
        send_item(3'd4, r0 & r3, r0 & ~r3, r1, r2, r2, r1, r0 & ~r3, r0 & r3);
        // every partition count code, random content with the table words reversed
        for (int pc = 0; pc < 8; pc++)
        begin
            r0 = rand_map();
            r1 = rand_map();
            r2 = rand_map();
            r3 = rand_map();
            send_item(parts_t'(pc), r0, r1, r2, r3, r3, r2, r1, r0);
        end
        send_item(3'd7, ALT_A, ALT_B, ONES, ZEROS, ONES, ZEROS, ALT_B, ALT_A);
        send_item(3'd1, ONES, ZEROS, ZEROS, ZEROS, ZEROS, ONES, ZEROS, ZEROS);
        send_item(3'd0, ALT_B, ALT_B, ALT_A, ALT_A, ALT_A, ALT_A, ALT_B, ALT_B);

        // random part: mostly well-formed partitionings, some noise
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 9) < 7)
                send_partitioned();
            else
                send_noise();
        end
        in_valid <= 1'b0;

        // drain
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
